[rtl/ces_pkg.sv]
// Package: shared constants, command codes and state type for the event scheduler.
package ces_pkg;
    localparam int NUM_SLOTS_DEF = 32;
    localparam int SLOT_W = 5;
    localparam int AMT_W = 32;
    localparam int FREQ_W = 10;
    localparam int TIME_W = 64;
    localparam logic [FREQ_W-1:0] FREQ_RESET = 10'd25;

    typedef enum logic [2:0] {
        CMD_ADVANCE   = 3'd0,
        CMD_ADD_CYC   = 3'd1,
        CMD_UPD_CYC   = 3'd2,
        CMD_ADD_US    = 3'd3,
        CMD_UPD_US    = 3'd4,
        CMD_REMOVE    = 3'd5,
        CMD_QUERY     = 3'd6,
        CMD_RSVD      = 3'd7
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_RD_OLD,
        ST_UNLINK,
        ST_CALC,
        ST_WALK_RD,
        ST_WALK,
        ST_LINK,
        ST_ACK,
        ST_ADV_RD,
        ST_ADV,
        ST_FIRE,
        ST_CLEAR
    } state_t;
endpackage

[rtl/ces_if.sv]
// Interfaces: valid/ready channels for commands and results.
interface ces_cmd_if;
    logic                       valid;
    logic                       ready;
    logic [2:0]                 command;
    logic [ces_pkg::SLOT_W-1:0] slot;
    logic [ces_pkg::AMT_W-1:0]  amount;
    modport source (output valid, command, slot, amount, input ready);
    modport sink (input valid, command, slot, amount, output ready);
endinterface

interface ces_res_if;
    logic                       valid;
    logic                       ready;
    logic                       kind;
    logic [ces_pkg::SLOT_W-1:0] slot_id;
    logic                       active;
    logic [ces_pkg::TIME_W-1:0] now_cycles;
    logic                       last;
    modport source (output valid, kind, slot_id, active, now_cycles, last, input ready);
    modport sink (input valid, kind, slot_id, active, now_cycles, last, output ready);
endinterface

[rtl/cycle_event_scheduler_unit.sv]
// Top level: timed event scheduler keeping slots in a deadline-ordered linked list.
// Add/update unlink the slot when it is pending, then walk the list from the head to
// find the insert point; remove unlinks a pending slot and query only reads it.
// Advance fires due slots one by one from the head; each result waits on res.ready.
// One command is handled at a time: a new one is taken only when idle with no result
// pending; the walk reads one slot memory entry per step.
// Reset: control, head and counter clear and cpu_freq loads FREQ_RESET at once; a
// clearing pass then writes all-ones deadlines, null links and clear pending bits, no items taken.
module cycle_event_scheduler_unit #(
    parameter int NUM_SLOTS = ces_pkg::NUM_SLOTS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [ces_pkg::FREQ_W-1:0] cfg_wdata,
    ces_cmd_if.sink                    cmd,
    ces_res_if.source                  res
);
    localparam int IW = $clog2(NUM_SLOTS);
    localparam int TW = ces_pkg::TIME_W;
    localparam int SW = ces_pkg::SLOT_W;
    localparam int EW = TW + 2 * IW + 1;
    localparam int PW = ces_pkg::AMT_W + ces_pkg::FREQ_W;

    // Slot memory entry: {pending, next, prev, deadline}.
    logic [EW-1:0] mem [NUM_SLOTS];
    logic [EW-1:0] rd_data;
    logic          we;
    logic [IW-1:0] waddr, raddr;
    logic [EW-1:0] wdata;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data <= mem[raddr];
    end

    function automatic logic [EW-1:0] pack(logic p, logic [IW-1:0] n, logic [IW-1:0] pv,
                                           logic [TW-1:0] d);
        return {p, n, pv, d};
    endfunction

    wire            rd_pend = rd_data[EW-1];
    wire [IW-1:0]   rd_next = rd_data[EW-2 -: IW];
    wire [IW-1:0]   rd_prev = rd_data[TW +: IW];
    wire [TW-1:0]   rd_dl   = rd_data[TW-1:0];

    ces_pkg::state_t state_reg, state_next;
    logic [ces_pkg::FREQ_W-1:0] freq_reg;
    logic [TW-1:0]  now_reg, now_next;
    logic [IW-1:0]  head_reg, head_next;
    logic [2:0]     cmd_reg, cmd_next;
    logic [SW-1:0]  slot_reg, slot_next;
    logic [IW-1:0]  sidx_reg, sidx_next;
    logic           usable_reg, usable_next;
    logic [TW-1:0]  delta_reg, delta_next;
    logic [TW-1:0]  dl_reg, dl_next;       // new deadline of target
    logic [TW-1:0]  old_reg, old_next;     // old entry deadline
    logic [IW-1:0]  on_reg, on_next, op_reg, op_next;
    logic           opend_reg, opend_next;
    logic [IW-1:0]  wp_reg, wp_next, wn_reg, wn_next; // walk prev/current
    logic [IW-1:0]  cnt_reg, cnt_next;
    logic [1:0]     phase_reg, phase_next; // link-fix subphase
    logic           fired_reg, fired_next;
    logic           ov_reg, ov_next;
    logic           okind_reg, okind_next, oact_reg, oact_next, olast_reg, olast_next;
    logic [SW-1:0]  oslot_reg, oslot_next;

    wire cmd_fire = cmd.valid && cmd.ready;
    wire res_free = !ov_reg || res.ready;
    wire [IW:0] cnt_ext = {1'b0, cnt_reg};
    // Head entry is due once its deadline is at or below the counter.
    wire adv_due = (head_reg != '0) && (rd_dl <= now_reg) && (cnt_ext < NUM_SLOTS);

    assign cmd.ready      = (state_reg == ces_pkg::ST_IDLE) && !ov_reg;
    assign res.valid      = ov_reg;
    assign res.kind       = okind_reg;
    assign res.slot_id    = oslot_reg;
    assign res.active     = oact_reg;
    assign res.now_cycles = now_reg;
    assign res.last       = olast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ces_pkg::ST_CLEAR;
            freq_reg  <= ces_pkg::FREQ_RESET;
            now_reg   <= '0;
            head_reg  <= '0;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
            phase_reg <= '0;
            fired_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            freq_reg  <= cfg_we ? cfg_wdata : freq_reg;
            now_reg   <= now_next;
            head_reg  <= head_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
            phase_reg <= phase_next;
            fired_reg <= fired_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        slot_reg   <= slot_next;
        sidx_reg   <= sidx_next;
        usable_reg <= usable_next;
        delta_reg  <= delta_next;
        dl_reg     <= dl_next;
        old_reg    <= old_next;
        on_reg     <= on_next;
        op_reg     <= op_next;
        opend_reg  <= opend_next;
        wp_reg     <= wp_next;
        wn_reg     <= wn_next;
        okind_reg  <= okind_next;
        oact_reg   <= oact_next;
        olast_reg  <= olast_next;
        oslot_reg  <= oslot_next;
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ces_pkg::ST_CLEAR:
                if (cnt_ext == NUM_SLOTS - 1) state_next = ces_pkg::ST_IDLE;
            ces_pkg::ST_IDLE:
                if (cmd_fire)
                begin
                    if (cmd.command == ces_pkg::CMD_ADVANCE) state_next = ces_pkg::ST_ADV_RD;
                    else state_next = ces_pkg::ST_MUL;
                end
            ces_pkg::ST_MUL:     state_next = ces_pkg::ST_RD_OLD;
            ces_pkg::ST_RD_OLD:  state_next = ces_pkg::ST_UNLINK;
            ces_pkg::ST_UNLINK:
                if (!usable_reg || cmd_reg == ces_pkg::CMD_QUERY
                    || cmd_reg == ces_pkg::CMD_RSVD)
                    state_next = ces_pkg::ST_ACK;
                else if (!opend_reg || phase_reg == 2'd2)
                    state_next = (cmd_reg == ces_pkg::CMD_REMOVE) ? ces_pkg::ST_ACK
                                                                  : ces_pkg::ST_CALC;
            ces_pkg::ST_CALC:    state_next = ces_pkg::ST_WALK_RD;
            ces_pkg::ST_WALK_RD:
                state_next = (wn_reg == '0) ? ces_pkg::ST_LINK : ces_pkg::ST_WALK;
            ces_pkg::ST_WALK:
                if (!(rd_dl < dl_reg) || cnt_ext == NUM_SLOTS - 1) state_next = ces_pkg::ST_LINK;
                else state_next = ces_pkg::ST_WALK_RD;
            ces_pkg::ST_LINK:
                if (phase_reg == 2'd2) state_next = ces_pkg::ST_ACK;
            ces_pkg::ST_ACK:
                if (res_free) state_next = ces_pkg::ST_IDLE;
            ces_pkg::ST_ADV_RD:  state_next = ces_pkg::ST_ADV;
            ces_pkg::ST_ADV:
                if (res_free) state_next = adv_due ? ces_pkg::ST_FIRE : ces_pkg::ST_IDLE;
            ces_pkg::ST_FIRE:    state_next = ces_pkg::ST_ADV;
            default:             state_next = ces_pkg::ST_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb
    begin
        logic [PW-1:0] prod;
        prod = '0;
        now_next = now_reg;   head_next = head_reg;  cnt_next = cnt_reg;
        ov_next = ov_reg && !res.ready;
        phase_next = phase_reg; fired_next = fired_reg;
        cmd_next = cmd_reg;   slot_next = slot_reg;  sidx_next = sidx_reg;
        usable_next = usable_reg; delta_next = delta_reg; dl_next = dl_reg;
        old_next = old_reg;   on_next = on_reg;      op_next = op_reg;
        opend_next = opend_reg; wp_next = wp_reg;    wn_next = wn_reg;
        okind_next = okind_reg; oact_next = oact_reg; olast_next = olast_reg;
        oslot_next = oslot_reg;
        we = 1'b0; waddr = sidx_reg; wdata = '0; raddr = sidx_reg;
        unique case (state_reg)
            ces_pkg::ST_CLEAR:
            begin
                we = 1'b1; waddr = cnt_reg; wdata = pack(1'b0, '0, '0, '1);
                cnt_next = cnt_reg + 1'b1;
            end
            ces_pkg::ST_IDLE:
            begin
                cmd_next = cmd.command; slot_next = cmd.slot;
                sidx_next = IW'(cmd.slot);
                usable_next = (cmd.slot != '0) && ({1'b0, cmd.slot} < (SW+1)'(NUM_SLOTS));
                delta_next = {{(TW-ces_pkg::AMT_W){1'b0}}, cmd.amount};
                phase_next = '0; cnt_next = '0; fired_next = 1'b0;
                if (cmd_fire && cmd.command == ces_pkg::CMD_ADVANCE)
                    now_next = now_reg + {{(TW-ces_pkg::AMT_W){1'b0}}, cmd.amount};
                raddr = head_reg;
            end
            ces_pkg::ST_MUL:
            begin
                prod = delta_reg[ces_pkg::AMT_W-1:0] * freq_reg;
                if (cmd_reg == ces_pkg::CMD_ADD_US || cmd_reg == ces_pkg::CMD_UPD_US)
                    delta_next = {{(TW-PW){1'b0}}, prod};
                raddr = sidx_reg;
            end
            ces_pkg::ST_RD_OLD:
            begin
                old_next = rd_dl; on_next = rd_next; op_next = rd_prev;
                opend_next = rd_pend && usable_reg;
            end
            ces_pkg::ST_UNLINK:
            begin
                // Unlink in three steps: clear pending, fix prev, fix next.
                if (usable_reg && opend_reg && (cmd_reg != ces_pkg::CMD_QUERY)
                    && (cmd_reg != ces_pkg::CMD_RSVD))
                begin
                    unique case (phase_reg)
                        2'd0:
                        begin
                            // Hold deadline; drop pending until reinserted.
                            we = 1'b1; waddr = sidx_reg;
                            wdata = pack(1'b0, on_reg, op_reg, old_reg);
                            if (head_reg == sidx_reg) head_next = on_reg;
                            raddr = op_reg; phase_next = 2'd1;
                        end
                        2'd1:
                        begin
                            if (op_reg != '0)
                            begin
                                we = 1'b1; waddr = op_reg;
                                wdata = pack(rd_pend, on_reg, rd_prev, rd_dl);
                            end
                            raddr = on_reg; phase_next = 2'd2;
                        end
                        default:
                        begin
                            if (on_reg != '0)
                            begin
                                we = 1'b1; waddr = on_reg;
                                wdata = pack(rd_pend, rd_next, op_reg, rd_dl);
                            end
                            phase_next = '0;
                        end
                    endcase
                end
                if (state_next == ces_pkg::ST_ACK || state_next == ces_pkg::ST_CALC)
                begin
                    if (!usable_reg || cmd_reg == ces_pkg::CMD_QUERY
                        || cmd_reg == ces_pkg::CMD_RSVD)
                        oact_next = opend_reg;
                    else
                        oact_next = 1'b0;
                end
            end
            ces_pkg::ST_CALC:
            begin
                if (cmd_reg == ces_pkg::CMD_ADD_CYC || cmd_reg == ces_pkg::CMD_ADD_US)
                    dl_next = now_reg + delta_reg;
                else
                    dl_next = old_reg + delta_reg;
                wp_next = '0; wn_next = head_reg; cnt_next = '0;
            end
            ces_pkg::ST_WALK_RD:
                raddr = wn_reg;
            ces_pkg::ST_WALK:
            begin
                if ((rd_dl < dl_reg) && cnt_ext != NUM_SLOTS - 1)
                begin
                    wp_next = wn_reg; wn_next = rd_next; cnt_next = cnt_reg + 1'b1;
                end
                else if (rd_dl < dl_reg)
                begin
                    wp_next = wn_reg; wn_next = rd_next;
                end
            end
            ces_pkg::ST_LINK:
            begin
                unique case (phase_reg)
                    2'd0:
                    begin
                        we = 1'b1; waddr = sidx_reg;
                        wdata = pack(1'b1, wn_reg, wp_reg, dl_reg);
                        if (wp_reg == '0) head_next = sidx_reg;
                        raddr = wp_reg; phase_next = 2'd1;
                    end
                    2'd1:
                    begin
                        if (wp_reg != '0)
                        begin
                            we = 1'b1; waddr = wp_reg;
                            wdata = pack(rd_pend, sidx_reg, rd_prev, rd_dl);
                        end
                        raddr = wn_reg; phase_next = 2'd2;
                    end
                    default:
                    begin
                        if (wn_reg != '0)
                        begin
                            we = 1'b1; waddr = wn_reg;
                            wdata = pack(rd_pend, rd_next, sidx_reg, rd_dl);
                        end
                        phase_next = '0;
                        oact_next = 1'b1;
                    end
                endcase
            end
            ces_pkg::ST_ACK:
                if (res_free)
                begin
                    ov_next = 1'b1; okind_next = 1'b1; oslot_next = slot_reg;
                    olast_next = 1'b1;
                end
            ces_pkg::ST_ADV_RD:
                raddr = head_reg;
            ces_pkg::ST_ADV:
            begin
                // rd_data holds the head entry. A fired slot is held in slot_reg
                // until the next head shows whether it is the last one.
                raddr = head_reg;
                if (res_free)
                begin
                    if (fired_reg || !adv_due)
                    begin
                        ov_next = 1'b1;
                        okind_next = !fired_reg;
                        oslot_next = fired_reg ? slot_reg : '0;
                        oact_next = 1'b0;
                        olast_next = !adv_due;
                    end
                    if (adv_due)
                    begin
                        we = 1'b1; waddr = head_reg;
                        wdata = pack(1'b0, rd_next, rd_prev, rd_dl);
                        head_next = rd_next; cnt_next = cnt_reg + 1'b1;
                        fired_next = 1'b1;
                        slot_next = SW'(head_reg);
                        wn_next = rd_next;
                        raddr = rd_next;
                    end
                end
            end
            ces_pkg::ST_FIRE:
            begin
                // Clear the prev link of the new head and read it for the next check.
                raddr = head_reg;
                if (wn_reg != '0)
                begin
                    we = 1'b1; waddr = wn_reg;
                    wdata = pack(rd_pend, rd_next, '0, rd_dl);
                end
            end
            default: ;
        endcase
    end
endmodule

[rtl/ces_checker.sv]
// Checker: port-level properties of the scheduler, bound to the top level.
module ces_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       cmd_valid,
    input logic       cmd_ready,
    input logic       res_valid,
    input logic       res_ready,
    input logic       res_kind,
    input logic       res_last,
    input logic       res_active,
    input logic [4:0] res_slot_id
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid) else $error("result dropped");
    a_fire_inactive: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_kind |-> !res_active) else $error("fired slot active");
    a_fire_slot: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_kind |-> res_slot_id != 5'd0) else $error("null slot fired");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !cmd_ready) else $error("accept while result pending");
    a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind |-> res_last) else $error("acknowledge without last");
endmodule

bind cycle_event_scheduler_unit ces_checker u_ces_checker (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd.valid), .cmd_ready(cmd.ready),
    .res_valid(res.valid), .res_ready(res.ready), .res_kind(res.kind),
    .res_last(res.last), .res_active(res.active), .res_slot_id(res.slot_id)
);
